// ===== rtl/sii_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sii_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_HARTS_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 8;

  // Field widths
  localparam int MODE_W         = 2;
  localparam int WDATA_W        = 32;
  localparam int TICKS_W        = 32;
  localparam int COUNT_W        = 12;
  localparam int KIND_W         = 3;
  localparam int HART_W         = 5;
  localparam int KINDS_PER_HART = 6;
  localparam int LINES_OUT_W    = 24;

  // Field positions inside wdata
  localparam int SCH_COUNT_LSB = 0;
  localparam int SCH_KIND_LSB  = 12;
  localparam int SCH_HART_LSB  = 15;
  localparam int CLR_KIND_LSB  = 0;
  localparam int CLR_HART_LSB  = 3;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_MASK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCHED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [WDATA_W-1:0] wdata;
    logic [TICKS_W-1:0] ticks;
  } in_t;

  typedef struct packed {
    logic [LINES_OUT_W-1:0] irq_lines;
    logic                   dropped;
  } out_t;

  // Control broadcast along one hart's row of slot cells
  typedef struct packed {
    logic               step;     // item accepted this cycle
    logic               adv;      // run the countdown advance
    logic               en;       // hart enabled (mask after this beat)
    logic               ins_req;  // valid schedule aimed at this hart
    logic [TICKS_W-1:0] elapsed;
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] count;
  } cell_ctrl_t;

  // One-hot of a kind; all zero for the two unused kind codes
  function automatic logic [KINDS_PER_HART-1:0] kind_onehot(input logic [KIND_W-1:0] kind);
    logic [KINDS_PER_HART-1:0] v;
    v = '0;
    for (int k = 0; k < KINDS_PER_HART; k++) begin
      if (kind == KIND_W'(k)) begin
        v[k] = 1'b1;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scheduled_interrupt_injector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Flow: a beat taken on start raises busy, and busy in turn raises the result strobe;
// the result is taken at the edge that ends the strobe cycle.
// No new beat is taken while busy is high; the accept cycle updates every slot cell of
// every hart row at once, the busy cycle folds the fired kinds into the line register.
// The result receiver cannot stall; busy is high only in the cycle after a beat is taken.
// Reset (synchronous, rst_n low) clears the mask, all slot valid bits and lines.
module scheduled_interrupt_injector #(
  parameter int NUM_HARTS   = sii_pkg::NUM_HARTS_DEF,
  parameter int QUEUE_DEPTH = sii_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire sii_pkg::in_t  in_data,
  output logic               out_strobe,
  output sii_pkg::out_t      out_data
);

  localparam int KPH = sii_pkg::KINDS_PER_HART;

  logic                          accept;
  logic                          phase_r;
  logic                          strobe_r;
  sii_pkg::out_t                 out_r;
  logic                          drop_r, drop_nxt;
  logic [NUM_HARTS-1:0]          mask_r, mask_nxt;
  logic [sii_pkg::KIND_W-1:0]    sch_kind, clr_kind;
  logic [sii_pkg::HART_W-1:0]    sch_hart, clr_hart;
  logic [sii_pkg::COUNT_W-1:0]   sch_count;
  logic [sii_pkg::TICKS_W-1:0]   elapsed;
  logic                          kind_ok, hart_ok, full_sel, fire_any;
  logic [KPH-1:0]                clr_oh;
  logic [KPH-1:0]                line_r   [NUM_HARTS];
  logic [KPH-1:0]                line_nxt [NUM_HARTS];
  sii_pkg::cell_ctrl_t           lane_ctrl [NUM_HARTS];
  logic                          full [NUM_HARTS];
  logic [KPH-1:0]                fire [NUM_HARTS];
  logic [sii_pkg::LINES_OUT_W-1:0] irq;

  assign accept     = start & ~phase_r;
  assign busy       = phase_r;
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  // Field decode
  assign sch_count = in_data.wdata[sii_pkg::SCH_COUNT_LSB +: sii_pkg::COUNT_W];
  assign sch_kind  = in_data.wdata[sii_pkg::SCH_KIND_LSB +: sii_pkg::KIND_W];
  assign sch_hart  = in_data.wdata[sii_pkg::SCH_HART_LSB +: sii_pkg::HART_W];
  assign clr_kind  = in_data.wdata[sii_pkg::CLR_KIND_LSB +: sii_pkg::KIND_W];
  assign clr_hart  = in_data.wdata[sii_pkg::CLR_HART_LSB +: sii_pkg::HART_W];
  assign clr_oh    = sii_pkg::kind_onehot(clr_kind);
  assign kind_ok   = sch_kind < sii_pkg::KIND_W'(KPH);
  assign hart_ok   = sch_hart < sii_pkg::HART_W'(NUM_HARTS);
  assign elapsed   = (in_data.mode == sii_pkg::MODE_TICK) ? in_data.ticks : '0;
  assign mask_nxt  = (in_data.mode == sii_pkg::MODE_MASK) ?
                     in_data.wdata[NUM_HARTS-1:0] : mask_r;

  // Hart rows
  for (genvar h = 0; h < NUM_HARTS; h++) begin : g_hart
    always_comb begin
      lane_ctrl[h].step    = accept;
      lane_ctrl[h].adv     = in_data.mode != sii_pkg::MODE_CLEAR;
      lane_ctrl[h].en      = mask_nxt[h];
      lane_ctrl[h].ins_req = (in_data.mode == sii_pkg::MODE_SCHED) && kind_ok &&
                             (sch_hart == sii_pkg::HART_W'(h));
      lane_ctrl[h].elapsed = elapsed;
      lane_ctrl[h].kind    = sch_kind;
      lane_ctrl[h].count   = sch_count;
    end

    sii_lane #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl[h]),
      .full  (full[h]),
      .fire  (fire[h])
    );
  end

  // Refusal: bad kind, absent hart or full row
  always_comb begin
    full_sel = 1'b0;
    fire_any = 1'b0;
    for (int h = 0; h < NUM_HARTS; h++) begin
      if (sch_hart == sii_pkg::HART_W'(h)) begin
        full_sel = full_sel | full[h];
      end
      fire_any = fire_any | (|fire[h]);
    end
    drop_nxt = (in_data.mode == sii_pkg::MODE_SCHED) && (!kind_ok || !hart_ok || full_sel);
  end

  // Line register: clear on the accept cycle, fired kinds on the busy cycle
  always_comb begin
    for (int h = 0; h < NUM_HARTS; h++) begin
      line_nxt[h] = line_r[h];
      if (accept && (in_data.mode == sii_pkg::MODE_CLEAR) &&
          (clr_hart == sii_pkg::HART_W'(h))) begin
        line_nxt[h] = line_nxt[h] & ~clr_oh;
      end
      if (phase_r) begin
        line_nxt[h] = line_nxt[h] | fire[h];
      end
    end
  end

  // Visible lines: first four harts only
  for (genvar i = 0; i < sii_pkg::LINES_OUT_W; i++) begin : g_irq
    localparam int HI = i / KPH;
    localparam int KI = i % KPH;
    if (HI < NUM_HARTS) begin : g_on
      assign irq[i] = line_nxt[HI][KI];
    end else begin : g_off
      assign irq[i] = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      strobe_r <= 1'b0;
      mask_r   <= '0;
      for (int h = 0; h < NUM_HARTS; h++) begin
        line_r[h] <= '0;
      end
    end else begin
      phase_r  <= accept;
      strobe_r <= phase_r;
      if (accept) begin
        mask_r <= mask_nxt;
      end
      for (int h = 0; h < NUM_HARTS; h++) begin
        line_r[h] <= line_nxt[h];
      end
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      drop_r <= drop_nxt;
    end
    if (phase_r) begin
      out_r.irq_lines <= irq;
      out_r.dropped   <= drop_r;
    end
  end

  // Checks
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(phase_r))
    else $error("result strobe without a preceding busy cycle");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |=> !phase_r)
    else $error("busy held for more than one cycle");

  a_drop_only_sched: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.mode != sii_pkg::MODE_SCHED)) |=> !drop_r)
    else $error("refusal flagged for a non-schedule beat");

  a_no_fire_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.mode == sii_pkg::MODE_CLEAR)) |=> !fire_any)
    else $error("slot fired on a clear beat");

endmodule

`default_nettype wire

// ===== rtl/sii_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One pending slot: valid, kind and countdown
module sii_cell (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sii_pkg::cell_ctrl_t                 ctrl,
  input  wire logic                                free_in,
  input  wire logic [sii_pkg::KINDS_PER_HART-1:0]  fire_in,
  output logic                                     free_out,
  output logic [sii_pkg::KINDS_PER_HART-1:0]       fire_out
);

  logic                               valid_r, valid_nxt;
  logic [sii_pkg::KIND_W-1:0]         kind_r, kind_nxt;
  logic [sii_pkg::COUNT_W-1:0]        cnt_r, cnt_nxt;
  logic [sii_pkg::KINDS_PER_HART-1:0] fire_r, fire_nxt;
  logic                               ins;
  logic                               v1;
  logic [sii_pkg::KIND_W-1:0]         k1;
  logic [sii_pkg::COUNT_W-1:0]        c1;
  logic                               due;

  // First free cell of the row takes the insert
  assign ins      = ctrl.ins_req & ~valid_r & ~free_in;
  assign free_out = free_in | ~valid_r;
  assign fire_out = fire_in | fire_r;

  assign v1 = valid_r | ins;
  assign k1 = ins ? ctrl.kind : kind_r;
  assign c1 = ins ? ctrl.count : cnt_r;

  // Countdown has run out when it does not exceed the elapsed time
  assign due = (ctrl.elapsed[sii_pkg::TICKS_W-1:sii_pkg::COUNT_W] != '0) ||
               (c1 <= ctrl.elapsed[sii_pkg::COUNT_W-1:0]);

  always_comb begin
    valid_nxt = v1;
    kind_nxt  = k1;
    cnt_nxt   = c1;
    fire_nxt  = '0;
    if (ctrl.adv && v1) begin
      if (!ctrl.en) begin
        valid_nxt = 1'b0;
      end else if (due) begin
        valid_nxt = 1'b0;
        fire_nxt  = sii_pkg::kind_onehot(k1);
      end else begin
        cnt_nxt = c1 - ctrl.elapsed[sii_pkg::COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      fire_r  <= '0;
    end else if (ctrl.step) begin
      valid_r <= valid_nxt;
      fire_r  <= fire_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      kind_r <= kind_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sii_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Row of slot cells for one hart
module sii_lane #(
  parameter int QUEUE_DEPTH = sii_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sii_pkg::cell_ctrl_t                 ctrl,
  output logic                                     full,
  output logic [sii_pkg::KINDS_PER_HART-1:0]       fire
);

  logic                               free_c [QUEUE_DEPTH+1];
  logic [sii_pkg::KINDS_PER_HART-1:0] fire_c [QUEUE_DEPTH+1];

  assign free_c[0] = 1'b0;
  assign fire_c[0] = '0;

  for (genvar s = 0; s < QUEUE_DEPTH; s++) begin : g_cell
    sii_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .free_in  (free_c[s]),
      .fire_in  (fire_c[s]),
      .free_out (free_c[s+1]),
      .fire_out (fire_c[s+1])
    );
  end

  assign full = ~free_c[QUEUE_DEPTH];
  assign fire = fire_c[QUEUE_DEPTH];

endmodule

`default_nettype wire
